[rtl/xrs_pkg.sv]
`default_nettype none

package xrs_pkg;

    // multiplier of the seed expansion and its square modulo 2^64
    localparam logic [63:0] K_MULT = 64'd1181783497276652981;
    localparam logic [63:0] K_SQ   = K_MULT * K_MULT;

    // rotate and shift amounts of the state update
    localparam int unsigned ROT_A   = 55;
    localparam int unsigned SHIFT_B = 14;
    localparam int unsigned ROT_C   = 36;

    // command codes carried in tuser
    localparam logic [2:0] CMD_RESEED    = 3'd0;
    localparam logic [2:0] CMD_RAW64     = 3'd1;
    localparam logic [2:0] CMD_TOP32     = 3'd2;
    localparam logic [2:0] CMD_BOUNDED32 = 3'd3;
    localparam logic [2:0] CMD_BOUNDED16 = 3'd4;
    localparam logic [2:0] CMD_FRACTION  = 3'd5;

    // control from the sequencer to the state registers
    typedef struct packed {
        logic adv;
        logic load_a;
        logic load_b;
    } t_state_ctl;

endpackage

`default_nettype wire

[rtl/xrs_mul.sv]
`default_nettype none

module xrs_mul (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_op_a,
    input  wire logic [31:0] i_op_b,
    output logic      [63:0] o_prod
);

    logic [63:0] r_prod;

    // shared 32x32 multiplier, product registered
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_op_a) * 64'(i_op_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

[rtl/xrs_state.sv]
`default_nettype none

module xrs_state (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire xrs_pkg::t_state_ctl i_ctl,
    input  wire logic       [63:0] i_load_value,
    output logic            [63:0] o_sum
);

    logic [63:0] r_word_a;
    logic [63:0] r_word_b;
    logic [63:0] n_word_a;
    logic [63:0] n_word_b;
    logic [63:0] w_t;

    // output of the generator is the sum before the update
    assign o_sum = r_word_a + r_word_b;
    assign w_t   = r_word_a ^ r_word_b;

    // next state: one update step, or a load from the seed expansion
    always_comb begin
        n_word_a = r_word_a;
        n_word_b = r_word_b;
        if (i_ctl.adv) begin
            n_word_a = ((r_word_a << xrs_pkg::ROT_A) | (r_word_a >> (64 - xrs_pkg::ROT_A)))
                       ^ w_t ^ (w_t << xrs_pkg::SHIFT_B);
            n_word_b = (w_t << xrs_pkg::ROT_C) | (w_t >> (64 - xrs_pkg::ROT_C));
        end
        if (i_ctl.load_a) begin
            n_word_a = i_load_value;
        end
        if (i_ctl.load_b) begin
            n_word_b = i_load_value;
        end
    end

    // state words, reset to the expansion of seed one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_a <= xrs_pkg::K_MULT;
            r_word_b <= xrs_pkg::K_SQ;
        end else begin
            r_word_a <= n_word_a;
            r_word_b <= n_word_b;
        end
    end

endmodule

`default_nettype wire

[rtl/xoroshiro128plus_rng_unit.sv]
// xoroshiro128+ random number unit.
// Input channel s_axis: tuser carries the command (reseed, raw64, top32,
// bounded32, bounded16, fraction24), tdata carries the bound. Output channel
// m_axis: tdata carries the 64-bit result, zero-extended. A reseed and the
// unused command codes give no output word.
// Configuration: i_cfg_we writes i_cfg_wdata into the seed register in the same
// edge; a later reseed command expands it into the two state words.
// Raw64, top32 and fraction24 pass S_GEN and S_OUT to the output register;
// bounded32 and bounded16 pass S_GEN, S_BND and S_OUT (one pass through the
// shared 32x32 multiplier). A reseed runs S_RS0 to S_RS3 twice: six partial
// products on that multiplier, two 64-bit products in a chain. Unused codes
// are dropped in the accept cycle. One command is worked at a time;
// s_axis_tready is high only while the sequencer is idle. The output register
// holds a finished word, so the next command is taken while that word waits; a
// second result waits in the sequencer until the receiver takes the first.
// Reset (synchronous, active low) sets the seed to one and the state to the
// expansion of seed one, and empties the output register.
`default_nettype none

module xoroshiro128plus_rng_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // seed register write
    input  wire logic        i_cfg_we,
    input  wire logic [63:0] i_cfg_wdata,
    // command channel
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] bound
    input  wire logic [2:0]  s_axis_tuser,   // [2:0] cmd
    // result channel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [63:0] m_axis_tdata    // [63:0] random_value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RS0,
        S_RS1,
        S_RS2,
        S_RS3,
        S_GEN,
        S_BND,
        S_OUT
    } t_seq_state;

    t_seq_state r_state;
    t_seq_state n_state;

    logic [63:0] r_seed;
    logic [63:0] n_seed;
    logic        r_phase;
    logic        n_phase;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [63:0] r_out_data;
    logic [63:0] n_out_data;
    logic [63:0] r_x;
    logic [63:0] n_x;
    logic [63:0] r_acc;
    logic [63:0] n_acc;
    logic [63:0] r_sum;
    logic [63:0] n_sum;
    logic [63:0] r_res;
    logic [63:0] n_res;
    logic [2:0]  r_cmd;
    logic [2:0]  n_cmd;
    logic [31:0] r_bound;
    logic [31:0] n_bound;

    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_prod;
    logic [63:0] w_sum;
    logic [63:0] w_seed_prod;

    xrs_pkg::t_state_ctl w_ctl;

    xrs_mul u_mul (
        .i_clk  (i_clk),
        .i_op_a (w_mul_a),
        .i_op_b (w_mul_b),
        .o_prod (w_prod)
    );

    xrs_state u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_load_value (w_seed_prod),
        .o_sum        (w_sum)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // low 64 bits of K times x: low cross terms folded into the upper half
    assign w_seed_prod = {r_acc[63:32] + w_prod[31:0], r_acc[31:0]};

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_seed      = r_seed;
        n_phase     = r_phase;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_x         = r_x;
        n_acc       = r_acc;
        n_sum       = r_sum;
        n_res       = r_res;
        n_cmd       = r_cmd;
        n_bound     = r_bound;
        w_mul_a     = 32'd0;
        w_mul_b     = 32'd0;
        w_ctl       = '0;

        // seed register write
        if (i_cfg_we) begin
            n_seed = i_cfg_wdata;
        end

        // output word taken by the receiver
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    unique case (s_axis_tuser)
                        xrs_pkg::CMD_RESEED: begin
                            n_x     = r_seed;
                            n_phase = 1'b0;
                            n_state = S_RS0;
                        end
                        xrs_pkg::CMD_RAW64, xrs_pkg::CMD_TOP32,
                        xrs_pkg::CMD_BOUNDED32, xrs_pkg::CMD_BOUNDED16,
                        xrs_pkg::CMD_FRACTION: begin
                            w_ctl.adv = 1'b1;
                            n_sum     = w_sum;
                            n_cmd     = s_axis_tuser;
                            n_bound   = s_axis_tdata;
                            n_state   = S_GEN;
                        end
                        default: begin
                            // unused codes are dropped
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            // seed expansion: low x low, then the two cross terms
            S_RS0: begin
                w_mul_a = xrs_pkg::K_MULT[31:0];
                w_mul_b = r_x[31:0];
                n_state = S_RS1;
            end
            S_RS1: begin
                w_mul_a = xrs_pkg::K_MULT[31:0];
                w_mul_b = r_x[63:32];
                n_acc   = w_prod;
                n_state = S_RS2;
            end
            S_RS2: begin
                w_mul_a = xrs_pkg::K_MULT[63:32];
                w_mul_b = r_x[31:0];
                n_acc   = w_seed_prod;
                n_state = S_RS3;
            end
            S_RS3: begin
                if (!r_phase) begin
                    w_ctl.load_a = 1'b1;
                    n_x          = w_seed_prod;
                    n_phase      = 1'b1;
                    n_state      = S_RS0;
                end else begin
                    w_ctl.load_b = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            // result forming
            S_GEN: begin
                unique case (r_cmd)
                    xrs_pkg::CMD_BOUNDED32: begin
                        w_mul_a = r_sum[63:32];
                        w_mul_b = r_bound;
                        n_state = S_BND;
                    end
                    xrs_pkg::CMD_BOUNDED16: begin
                        w_mul_a = {16'd0, r_sum[63:48]};
                        w_mul_b = {16'd0, r_bound[15:0]};
                        n_state = S_BND;
                    end
                    xrs_pkg::CMD_RAW64: begin
                        n_res   = r_sum;
                        n_state = S_OUT;
                    end
                    xrs_pkg::CMD_TOP32: begin
                        n_res   = {32'd0, r_sum[63:32]};
                        n_state = S_OUT;
                    end
                    default: begin
                        n_res   = {40'd0, r_sum[63:40]};
                        n_state = S_OUT;
                    end
                endcase
            end
            S_BND: begin
                if (r_cmd == xrs_pkg::CMD_BOUNDED32) begin
                    n_res = {32'd0, w_prod[63:32]};
                end else begin
                    n_res = {48'd0, w_prod[31:16]};
                end
                n_state = S_OUT;
            end
            // hand the word to the output register once it is free
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_data  = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, seed register, output register and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= 64'd1;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seed      <= n_seed;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
        r_x        <= n_x;
        r_acc      <= n_acc;
        r_sum      <= n_sum;
        r_res      <= n_res;
        r_cmd      <= n_cmd;
        r_bound    <= n_bound;
    end

endmodule

`default_nettype wire

[bench/rng_word_checker.sv]
`timescale 1ns / 100ps

module rng_word_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [63:0] i_cfg_wdata,
    input  wire logic        i_cmd_valid,
    input  wire logic        i_cmd_ready,
    input  wire logic [31:0] i_cmd_bound,
    input  wire logic [2:0]  i_cmd_code,
    input  wire logic        i_word_valid,
    input  wire logic        i_word_ready,
    input  wire logic [63:0] i_word_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_word_count
);

    // shadow copy of the seed register and the generator state
    logic [63:0] seed_copy;
    logic [63:0] gen_a;
    logic [63:0] gen_b;

    // words still owed by the block, oldest first
    logic [63:0] owed_words[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_word_count = 0;
        seed_copy    = 64'd1;
    end

    // expand a seed into both state words
    task automatic expand_seed(input logic [63:0] seed);
        gen_a = xrs_pkg::K_MULT * seed;
        gen_b = xrs_pkg::K_MULT * gen_a;
    endtask

    // sum of the state words, then advance the state once
    task automatic draw_sum(output logic [63:0] sum);
        logic [63:0] mix;
        sum   = gen_a + gen_b;
        mix   = gen_a ^ gen_b;
        gen_a = ((gen_a << xrs_pkg::ROT_A) | (gen_a >> (64 - xrs_pkg::ROT_A)))
                ^ mix ^ (mix << xrs_pkg::SHIFT_B);
        gen_b = (mix << xrs_pkg::ROT_C) | (mix >> (64 - xrs_pkg::ROT_C));
    endtask

    // shape the raw sum into the word that the command asks for
    function automatic logic [63:0] shape_word(input logic [2:0] code,
                                               input logic [31:0] bound,
                                               input logic [63:0] sum);
        case (code)
            xrs_pkg::CMD_RAW64:
                return sum;
            xrs_pkg::CMD_TOP32:
                return {32'd0, sum[63:32]};
            xrs_pkg::CMD_BOUNDED32:
                return ({32'd0, sum[63:32]} * {32'd0, bound}) >> 32;
            xrs_pkg::CMD_BOUNDED16:
                return ({48'd0, sum[63:48]} * {48'd0, bound[15:0]}) >> 16;
            default:
                return {40'd0, sum[63:40]};
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        logic [63:0] sum;
        logic [63:0] owed;
        if (!i_rst_n) begin
            seed_copy = 64'd1;
            expand_seed(64'd1);
            owed_words.delete();
        end else begin
            // result side first: a word never belongs to a command taken in the same edge
            if (i_word_valid && i_word_ready) begin
                o_word_count++;
                if (owed_words.size() == 0) begin
                    o_fail_count++;
                    $error("random_value: expected none, actual %h", i_word_data);
                end else begin
                    owed = owed_words.pop_front();
                    if (owed !== i_word_data) begin
                        o_fail_count++;
                        $error("random_value: expected %h, actual %h", owed, i_word_data);
                    end
                end
            end
            // command side
            if (i_cmd_valid && i_cmd_ready) begin
                if (i_cmd_code == xrs_pkg::CMD_RESEED) begin
                    expand_seed(seed_copy);
                end else if (i_cmd_code <= xrs_pkg::CMD_FRACTION) begin
                    draw_sum(sum);
                    owed_words.push_back(shape_word(i_cmd_code, i_cmd_bound, sum));
                end
            end
            // seed register write
            if (i_cfg_we)
                seed_copy = i_cfg_wdata;
        end
        o_pending = owed_words.size();
    end

endmodule

[bench/tb_xoroshiro128plus_rng_unit.sv]
`timescale 1ns / 100ps

module tb_xoroshiro128plus_rng_unit;

    // command codes the block drops
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [63:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] bound
    logic [2:0]  s_axis_tuser;   // [2:0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [63:0] random_value

    int fail_count;
    int pending;
    int word_count;

    // stimulus bookkeeping
    int n_generate;
    int n_reseed;
    int n_dropped;
    int n_seeds;
    int n_sent;
    bit send_burst;

    xoroshiro128plus_rng_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rng_word_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd_valid  (s_axis_tvalid),
        .i_cmd_ready  (s_axis_tready),
        .i_cmd_bound  (s_axis_tdata),
        .i_cmd_code   (s_axis_tuser),
        .i_word_valid (m_axis_tvalid),
        .i_word_ready (m_axis_tready),
        .i_word_data  (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_word_count (word_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #1000000;
        $display("tb_xoroshiro128plus_rng_unit: FAIL");
        $finish;
    end

    // result receiver with random stalls and two long hold-offs
    initial begin : result_sink
        int taken;
        int gap;
        bit burst;
        taken = 0;
        burst = 1'b0;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (taken % 50 == 0)
                burst = ($urandom_range(0, 3) == 0);
            // long hold so the block backs up into the command channel
            if (taken == 40 || taken == 700) begin
                m_axis_tready <= 1'b0;
                repeat (90) @(posedge i_clk);
            end
            gap = burst ? 0 : $urandom_range(0, 13);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            taken++;
        end
    end

    // offer one command word and wait until it is taken
    task automatic send_cmd(input logic [2:0] code, input logic [31:0] bound);
        int gap;
        if (n_sent % 40 == 0)
            send_burst = ($urandom_range(0, 2) == 0);
        gap = send_burst ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= code;
        s_axis_tdata  <= bound;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        n_sent++;
        if (code == xrs_pkg::CMD_RESEED)
            n_reseed++;
        else if (code <= xrs_pkg::CMD_FRACTION)
            n_generate++;
        else
            n_dropped++;
    endtask

    // drain every owed word, then leave room for a reseed still in flight
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [63:0] seed);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= seed;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        n_seeds++;
    endtask

    // bounds weighted toward zero, small values, near-max and powers of two
    function automatic logic [31:0] pick_bound();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return 32'd0;
            1, 2:    return $urandom_range(1, 20);
            3:       return 32'hFFFF_FFFF - $urandom_range(0, 20);
            4:       return 32'd1 << $urandom_range(0, 31);
            5:       return $urandom & 32'h0000_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // one seed setting followed by random commands
    task automatic run_phase(input logic [63:0] seed, input int n_items);
        int done;
        int pick;
        logic [2:0] code;
        settle();
        write_seed(seed);
        send_cmd(xrs_pkg::CMD_RESEED, $urandom);
        done = 1;
        while (done < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                code = xrs_pkg::CMD_RESEED;
            else if (pick < 10)
                code = pick[0] ? CMD_SPARE6 : CMD_SPARE7;
            else
                code = xrs_pkg::CMD_RAW64 + 3'($urandom_range(0, 4));
            send_cmd(code, pick_bound());
            if (code <= xrs_pkg::CMD_FRACTION)
                done++;
        end
    endtask

    // stimulus
    initial begin
        n_generate = 0;
        n_reseed   = 0;
        n_dropped  = 0;
        n_seeds    = 0;
        n_sent     = 0;
        send_burst = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= 64'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 32'd0;
        s_axis_tuser  <= xrs_pkg::CMD_RESEED;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every command and bound extremes from the reset state
        send_cmd(xrs_pkg::CMD_RAW64, 32'd0);
        send_cmd(xrs_pkg::CMD_TOP32, 32'hFFFF_FFFF);
        send_cmd(xrs_pkg::CMD_BOUNDED32, 32'd0);
        send_cmd(xrs_pkg::CMD_BOUNDED32, 32'hFFFF_FFFF);
        send_cmd(xrs_pkg::CMD_BOUNDED32, 32'd1);
        send_cmd(xrs_pkg::CMD_BOUNDED16, 32'd0);
        send_cmd(xrs_pkg::CMD_BOUNDED16, 32'h0000_FFFF);
        send_cmd(xrs_pkg::CMD_BOUNDED16, 32'hFFFF_0000);
        send_cmd(xrs_pkg::CMD_BOUNDED16, 32'd1);
        send_cmd(xrs_pkg::CMD_FRACTION, 32'd0);
        send_cmd(CMD_SPARE6, 32'hFFFF_FFFF);
        send_cmd(CMD_SPARE7, 32'h5555_AAAA);
        // reseed with the reset seed returns to the reset state
        send_cmd(xrs_pkg::CMD_RESEED, 32'd0);
        send_cmd(xrs_pkg::CMD_RAW64, 32'd0);

        // zero seed: the generator is stuck at zero
        settle();
        write_seed(64'd0);
        send_cmd(xrs_pkg::CMD_RESEED, 32'd0);
        send_cmd(xrs_pkg::CMD_RAW64, 32'd0);
        send_cmd(xrs_pkg::CMD_BOUNDED32, 32'hFFFF_FFFF);
        send_cmd(xrs_pkg::CMD_FRACTION, 32'd0);

        // all-ones seed
        settle();
        write_seed(64'hFFFF_FFFF_FFFF_FFFF);
        send_cmd(xrs_pkg::CMD_RESEED, 32'd0);
        send_cmd(xrs_pkg::CMD_RAW64, 32'd0);
        send_cmd(xrs_pkg::CMD_TOP32, 32'd0);
        send_cmd(xrs_pkg::CMD_BOUNDED16, 32'h0000_8000);

        // random phases over several seed settings
        run_phase({$urandom, $urandom}, 340);
        run_phase(64'hFFFF_FFFF_FFFF_FFFF, 340);
        run_phase(64'd0, 60);
        run_phase(64'h8000_0000_0000_0000, 340);
        run_phase({$urandom, $urandom}, 340);

        settle();
        $display("covered %0d commands: %0d generating, %0d reseeds, %0d dropped codes",
                 n_sent, n_generate, n_reseed, n_dropped);
        $display("checked %0d result words over %0d seed writes", word_count, n_seeds);
        if (fail_count == 0)
            $display("tb_xoroshiro128plus_rng_unit: PASS");
        else
            $display("tb_xoroshiro128plus_rng_unit: FAIL");
        $finish;
    end

endmodule

[xoroshiro128plus_rng_unit.f]
rtl/xrs_pkg.sv
rtl/xrs_mul.sv
rtl/xrs_state.sv
rtl/xoroshiro128plus_rng_unit.sv
bench/rng_word_checker.sv
bench/tb_xoroshiro128plus_rng_unit.sv
